>>> design/lpe_pkg.sv
// Shared types, constants and helpers for the LSB pixel embed/extract block.
package lpe_pkg;

    // Bit buffer geometry
    localparam int BUF_BITS = 32;
    localparam int CNT_W    = $clog2(BUF_BITS + 1);

    // Per-pixel payload bits: up to 8 per channel, three channels
    localparam int MAX_RES  = 3;
    localparam int STREAM_W = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EMBED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_BLUE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_GREEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_RED   = 2'd3;

    // Input and result kinds
    localparam logic KIND_BYTE      = 1'b0;
    localparam logic KIND_PIXEL     = 1'b1;
    localparam logic OUT_KIND_PIXEL = 1'b0;
    localparam logic OUT_KIND_BYTE  = 1'b1;

    typedef struct packed {
        logic       embed_mode;
        logic [3:0] bits_blue;
        logic [3:0] bits_green;
        logic [3:0] bits_red;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{embed_mode: 1'b1, bits_blue: 4'd3,
                                   bits_green: 4'd3, bits_red: 4'd3};

    typedef struct packed {
        logic [BUF_BITS-1:0] bit_buffer;
        logic [CNT_W-1:0]    buffered_bits;
        logic [7:0]          byte_acc;
        logic [2:0]          acc_bits;
        logic                overflow;
    } state_t;

    typedef struct packed {
        logic        out_kind;
        logic [31:0] pixel_out;
        logic [7:0]  byte_out;
        logic        short_of_bits;
        logic        overflow_seen;
        logic        last;
    } result_t;

    // Bit counts above eight act as eight
    function automatic logic [3:0] clamp_bits(input logic [3:0] n);
        return (n > 4'd8) ? 4'd8 : n;
    endfunction

endpackage

>>> design/lpe_datapath.sv
// Per-item datapath: next state and result items for one accepted input item.
module lpe_datapath
    import lpe_pkg::*;
(
    input  cfg_t                      cfg,
    input  state_t                    state,
    input  logic                      kind,
    input  logic [7:0]                payload_byte,
    input  logic [31:0]               pixel_in,
    output state_t                    state_nxt,
    output result_t [MAX_RES-1:0]     res,
    output logic [1:0]                res_cnt
);

    logic [3:0]          nb0, nb1, nb2;
    logic [4:0]          n_total;
    logic [CNT_W-1:0]    avail;
    logic [CNT_W-1:0]    left_sh;
    logic [CNT_W-1:0]    bb_left;
    logic [BUF_BITS-1:0] aligned;
    logic [STREAM_W-1:0] stream;
    logic [STREAM_W-1:0] take_mask;
    logic [STREAM_W-1:0] s_green, s_red;
    logic [7:0]          keep_b, keep_g, keep_r;
    logic [31:0]         pix_emb;
    logic                short_f;
    logic [STREAM_W-1:0] x_bits, r_bits;
    logic [7:0]          acc_al;
    logic [31:0]         seq;
    logic [31:0]         seq_sh;
    logic [4:0]          ext_total;
    logic [1:0]          n_bytes;
    logic [2:0]          rem;

    always_comb
    begin
        nb0     = clamp_bits(cfg.bits_blue);
        nb1     = clamp_bits(cfg.bits_green);
        nb2     = clamp_bits(cfg.bits_red);
        n_total = 5'(nb0) + 5'(nb1) + 5'(nb2);
        keep_b  = 8'hFF << nb0;
        keep_g  = 8'hFF << nb1;
        keep_r  = 8'hFF << nb2;

        // Embed: left-align the held bits, oldest in the top bit
        avail   = (CNT_W'(n_total) < state.buffered_bits) ? CNT_W'(n_total)
                                                          : state.buffered_bits;
        short_f = CNT_W'(n_total) > state.buffered_bits;
        left_sh = CNT_W'(BUF_BITS) - state.buffered_bits;
        aligned = state.bit_buffer << left_sh;
        for (int k = 0; k < STREAM_W; k++)
        begin
            stream[k] = aligned[BUF_BITS-1-k];
        end
        take_mask = ~({STREAM_W{1'b1}} << avail);
        stream    = stream & take_mask;
        s_green   = stream >> nb0;
        s_red     = stream >> (5'(nb0) + 5'(nb1));
        pix_emb[31:24] = pixel_in[31:24];
        pix_emb[7:0]   = (pixel_in[7:0]   & keep_b) | (stream[7:0]  & ~keep_b);
        pix_emb[15:8]  = (pixel_in[15:8]  & keep_g) | (s_green[7:0] & ~keep_g);
        pix_emb[23:16] = (pixel_in[23:16] & keep_r) | (s_red[7:0]   & ~keep_r);
        bb_left = state.buffered_bits - avail;

        // Extract: pack channel low bits into one stream, bit k = k-th bit read
        x_bits = STREAM_W'(pixel_in[7:0] & ~keep_b)
               | (STREAM_W'(pixel_in[15:8] & ~keep_g) << nb0)
               | (STREAM_W'(pixel_in[23:16] & ~keep_r) << (5'(nb0) + 5'(nb1)));
        for (int k = 0; k < STREAM_W; k++)
        begin
            r_bits[STREAM_W-1-k] = x_bits[k];
        end
        // Accumulated bits go first, oldest in the top bit of the sequence
        acc_al    = state.byte_acc << (4'd8 - 4'(state.acc_bits));
        seq       = {acc_al, 24'b0} | ({r_bits, 8'b0} >> state.acc_bits);
        ext_total = 5'(state.acc_bits) + n_total;
        n_bytes   = ext_total[4:3];
        rem       = ext_total[2:0];
        seq_sh    = seq << {n_bytes, 3'b000};

        // Defaults: state holds, no results
        state_nxt = state;
        res_cnt   = 2'd0;
        res       = '0;

        if (cfg.embed_mode)
        begin
            if (kind == KIND_BYTE)
            begin
                if (state.buffered_bits > CNT_W'(BUF_BITS - 8))
                begin
                    state_nxt.overflow = 1'b1;
                end
                else
                begin
                    state_nxt.bit_buffer    = {state.bit_buffer[BUF_BITS-9:0], payload_byte};
                    state_nxt.buffered_bits = state.buffered_bits + CNT_W'(8);
                end
            end
            else
            begin
                state_nxt.buffered_bits = bb_left;
                state_nxt.bit_buffer    = state.bit_buffer
                                        & ~({BUF_BITS{1'b1}} << bb_left);
                res_cnt                 = 2'd1;
                res[0].out_kind         = OUT_KIND_PIXEL;
                res[0].pixel_out        = pix_emb;
                res[0].short_of_bits    = short_f;
                res[0].overflow_seen    = state.overflow;
                res[0].last             = 1'b1;
            end
        end
        else if (kind == KIND_PIXEL)
        begin
            state_nxt.acc_bits = rem;
            state_nxt.byte_acc = seq_sh[31:24] >> (4'd8 - 4'(rem));
            res_cnt            = n_bytes;
            for (int i = 0; i < MAX_RES; i++)
            begin
                res[i].out_kind      = OUT_KIND_BYTE;
                res[i].byte_out      = seq[31-8*i -: 8];
                res[i].overflow_seen = state.overflow;
                res[i].last          = (2'(i) == n_bytes - 2'd1);
            end
        end
    end

endmodule

>>> design/lsb_pixel_embed_extract_top.sv
// Top level: LSB pixel embed/extract with stream ports and config write port.
// Result items are registered: they appear at the output in the cycle after the input item is accepted.
// Throughput: one item per cycle while the output is not stalled; an extract pixel that yields k bytes (k up to 3)
// holds the input until the single output port has drained them.
// Reset: bit buffer, byte accumulator, counts and overflow flag clear; config takes
// its defaults (embed, 3/3/3 bits); no clearing pass.
module lsb_pixel_embed_extract_top
    import lpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Config write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [3:0]           cfg_data,
    // Input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,   // payload_byte[7:0], pixel_in[39:8]
    input  logic                 s_axis_tuser,   // kind
    // Result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // pixel_out[31:0], byte_out[39:32],
                                                 // short_of_bits[40], overflow_seen[41]
    output logic                 m_axis_tuser,   // out_kind
    output logic                 m_axis_tlast    // last
);

    cfg_t                  cfg_reg, cfg_next;
    state_t                state_reg, state_nxt;
    result_t [MAX_RES-1:0] slot_reg, slot_next, dp_res;
    logic [1:0]            cnt_reg, cnt_next, dp_cnt;
    logic                  in_fire, out_fire;

    lpe_datapath u_dp (
        .cfg          (cfg_reg),
        .state        (state_reg),
        .kind         (s_axis_tuser),
        .payload_byte (s_axis_tdata[7:0]),
        .pixel_in     (s_axis_tdata[39:8]),
        .state_nxt    (state_nxt),
        .res          (dp_res),
        .res_cnt      (dp_cnt)
    );

    // Handshakes: take a new item once the held results will all be gone
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_axis_tready);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Output fields from the head slot
    assign m_axis_tdata = {6'b0, slot_reg[0].overflow_seen, slot_reg[0].short_of_bits,
                           slot_reg[0].byte_out, slot_reg[0].pixel_out};
    assign m_axis_tuser = slot_reg[0].out_kind;
    assign m_axis_tlast = slot_reg[0].last;

    // Config register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_EMBED_MODE: cfg_next.embed_mode = cfg_data[0];
                REG_BITS_BLUE:  cfg_next.bits_blue  = cfg_data;
                REG_BITS_GREEN: cfg_next.bits_green = cfg_data;
                REG_BITS_RED:   cfg_next.bits_red   = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Result slots: load on accept, shift toward the head on each output
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (in_fire)
        begin
            slot_next = dp_res;
            cnt_next  = dp_cnt;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < MAX_RES - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= CFG_RESET;
            state_reg <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            cnt_reg <= cnt_next;
            if (in_fire)
            begin
                state_reg <= state_nxt;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

>>> tb/tb_lsb_pixel_embed_extract_top.sv
`timescale 1ns / 100ps
// Testbench for the LSB pixel embed/extract block: directed table, then random phases.
module tb_lsb_pixel_embed_extract_top;
    import lpe_pkg::*;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_op_e;

    // One line of stimulus: a register write or an input item, with an optional
    // hand-written expectation for single-result embed pixels
    typedef struct {
        row_op_e              op;
        logic [CFG_IDX_W-1:0] idx;
        logic [3:0]           val;
        logic                 kind;
        logic [7:0]           pbyte;
        logic [31:0]          pix;
        bit                   typed;
        result_t              typed_res;
    } stim_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [3:0]           cfg_data      = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic [39:0]          s_axis_tdata  = '0;   // payload_byte[7:0], pixel_in[39:8]
    logic                 s_axis_tuser  = 1'b0; // kind
    logic                 m_axis_tready = 1'b0;
    logic                 cfg_ready;
    logic                 s_axis_tready;
    logic                 m_axis_tvalid;
    logic [47:0]          m_axis_tdata;         // pixel_out[31:0], byte_out[39:32],
                                                // short_of_bits[40], overflow_seen[41]
    logic                 m_axis_tuser;         // out_kind
    logic                 m_axis_tlast;         // last

    // Shadow copy of the block's configuration and state
    cfg_t                shadow_cfg;
    logic [BUF_BITS-1:0] stash_bits;
    int                  stash_cnt;
    logic [7:0]          gather_byte;
    int                  gather_cnt;
    logic                overflow_sticky;
    result_t             lsb_results_due[$];

    int      err_count  = 0;
    bit      calm_input = 1'b0;
    int      stall_left = 0;
    int      calm_left  = 0;
    result_t got_res;
    result_t want_res;

    always #5 clk = ~clk;

    lsb_pixel_embed_extract_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Effective payload bits of one channel: anything above eight acts as eight
    function automatic int chan_bits(input logic [3:0] n);
        return (n > 4'd8) ? 8 : int'(n);
    endfunction

    // Mostly short idles, now and then a long one
    function automatic int idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Bit counts biased toward zero, eight and the out-of-range codes
    function automatic logic [3:0] pick_bits();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 4'd0;
        if (r < 30)
            return 4'd8;
        if (r < 40)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(1, 7));
    endfunction

    function automatic stim_row_t item_row(input logic kind, input logic [7:0] pbyte,
                                           input logic [31:0] pix);
        stim_row_t row;
        row       = '{op: ROW_ITEM, default: '0};
        row.kind  = kind;
        row.pbyte = pbyte;
        row.pix   = pix;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [3:0] val);
        stim_row_t row;
        row     = '{op: ROW_CFG, default: '0};
        row.idx = idx;
        row.val = val;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [31:0] pix, input logic [31:0] tpix,
                                            input logic tshort, input logic tovf);
        stim_row_t row;
        row           = item_row(KIND_PIXEL, 8'h00, pix);
        row.typed     = 1'b1;
        row.typed_res = '{out_kind: OUT_KIND_PIXEL, pixel_out: tpix, byte_out: 8'h00,
                          short_of_bits: tshort, overflow_seen: tovf, last: 1'b1};
        return row;
    endfunction

    task automatic flag_error(input string msg);
        if (err_count < 10)
            $display("%0t: %s", $time, msg);
        err_count++;
    endtask

    // Work out the results of one accepted item and queue them
    task automatic compute_lsb_results(input logic kind, input logic [7:0] pbyte,
                                       input logic [31:0] pix);
        logic [3:0] raw [3];
        logic [7:0] chan;
        logic [7:0] add;
        logic [7:0] keep;
        int         nb;
        result_t    r;
        result_t    held;
        bit         have_held;
        raw[0] = shadow_cfg.bits_blue;
        raw[1] = shadow_cfg.bits_green;
        raw[2] = shadow_cfg.bits_red;
        have_held = 1'b0;
        if (shadow_cfg.embed_mode) begin
            if (kind == KIND_BYTE) begin
                // drop the byte once the buffer cannot take eight more bits
                if (stash_cnt > BUF_BITS - 8)
                    overflow_sticky = 1'b1;
                else begin
                    stash_bits = {stash_bits[BUF_BITS-9:0], pbyte};
                    stash_cnt += 8;
                end
            end else begin
                r           = '0;
                r.out_kind  = OUT_KIND_PIXEL;
                r.pixel_out = {pix[31:24], 24'h0};
                r.last      = 1'b1;
                // blue, green, red; oldest buffered bit lands in bit 0
                for (int c = 0; c < 3; c++) begin
                    nb   = chan_bits(raw[c]);
                    chan = pix[8*c +: 8];
                    add  = '0;
                    for (int j = 0; j < nb; j++) begin
                        if (stash_cnt > 0) begin
                            add[j] = stash_bits[stash_cnt-1];
                            stash_cnt--;
                        end else
                            r.short_of_bits = 1'b1;
                    end
                    keep = 8'hFF << nb;
                    r.pixel_out[8*c +: 8] = (chan & keep) | add;
                end
                if (stash_cnt < BUF_BITS)
                    stash_bits &= ~({BUF_BITS{1'b1}} << stash_cnt);
                r.overflow_seen = overflow_sticky;
                lsb_results_due.push_back(r);
            end
        end else if (kind == KIND_PIXEL) begin
            // low bits shifted in MSB first; each full byte becomes a result
            for (int c = 0; c < 3; c++) begin
                nb   = chan_bits(raw[c]);
                chan = pix[8*c +: 8];
                for (int j = 0; j < nb; j++) begin
                    gather_byte = {gather_byte[6:0], chan[j]};
                    gather_cnt++;
                    if (gather_cnt == 8) begin
                        if (have_held)
                            lsb_results_due.push_back(held);
                        held               = '0;
                        held.out_kind      = OUT_KIND_BYTE;
                        held.byte_out      = gather_byte;
                        held.overflow_seen = overflow_sticky;
                        have_held          = 1'b1;
                        gather_byte        = '0;
                        gather_cnt         = 0;
                    end
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                lsb_results_due.push_back(held);
            end
        end
    endtask

    // Present one item, wait for the handshake, then predict
    task automatic drive_item(input stim_row_t row);
        int gap;
        gap = (!calm_input && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.pix, row.pbyte};
        s_axis_tuser  <= row.kind;
        do @(posedge clk); while (!s_axis_tready);
        compute_lsb_results(row.kind, row.pbyte, row.pix);
        if (row.typed) begin
            void'(lsb_results_due.pop_back());
            lsb_results_due.push_back(row.typed_res);
        end
    endtask

    // Let every queued result drain, then allow for items still in flight
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (lsb_results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_EMBED_MODE: shadow_cfg.embed_mode = val[0];
            REG_BITS_BLUE:  shadow_cfg.bits_blue  = val;
            REG_BITS_GREEN: shadow_cfg.bits_green = val;
            REG_BITS_RED:   shadow_cfg.bits_red   = val;
            default:        ;
        endcase
    endtask

    // Result side backpressure: random stalls with calm stretches
    always @(posedge clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (calm_left > 0)
                calm_left--;
            else if ($urandom_range(0, 99) < 3)
                calm_left = $urandom_range(40, 150);
            else if ($urandom_range(0, 99) < 30)
                stall_left = idle_len();
        end
    end

    // Compare each result item with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got_res.out_kind      = m_axis_tuser;
            got_res.pixel_out     = m_axis_tdata[31:0];
            got_res.byte_out      = m_axis_tdata[39:32];
            got_res.short_of_bits = m_axis_tdata[40];
            got_res.overflow_seen = m_axis_tdata[41];
            got_res.last          = m_axis_tlast;
            if (lsb_results_due.size() == 0)
                flag_error($sformatf("unexpected item kind=%0b pix=%h byte=%h last=%0b",
                                     got_res.out_kind, got_res.pixel_out,
                                     got_res.byte_out, got_res.last));
            else begin
                want_res = lsb_results_due.pop_front();
                if (got_res !== want_res)
                    flag_error($sformatf({"mismatch exp kind=%0b pix=%h byte=%h short=%0b ",
                                          "ovf=%0b last=%0b / got kind=%0b pix=%h byte=%h ",
                                          "short=%0b ovf=%0b last=%0b"},
                                         want_res.out_kind, want_res.pixel_out,
                                         want_res.byte_out, want_res.short_of_bits,
                                         want_res.overflow_seen, want_res.last,
                                         got_res.out_kind, got_res.pixel_out,
                                         got_res.byte_out, got_res.short_of_bits,
                                         got_res.overflow_seen, got_res.last));
            end
        end
    end

    // Watchdog
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Stimulus
    initial begin
        stim_row_t  dir_rows[$];
        stim_row_t  row;
        logic [3:0] mode_val;
        logic [31:0] pix;
        int         counted;
        int         need;
        bit         take_byte;

        shadow_cfg      = CFG_RESET;
        stash_bits      = '0;
        stash_cnt       = 0;
        gather_byte     = '0;
        gather_cnt      = 0;
        overflow_sticky = 1'b0;

        // empty buffer after reset: every payload bit is a padded zero
        dir_rows.push_back(typed_row(32'hFFFF_FFFF, 32'hFFF8_F8F8, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hFF, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'h00, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hA5, 32'h0));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'h0000_0000));
        // full eight bits per channel, buffer runs short mid pixel
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd8));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd8));
        dir_rows.push_back(cfg_row(REG_BITS_RED, 4'd8));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hC3, 32'h0));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'hFFFF_FFFF));
        // no payload bits: pixel passes untouched
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd0));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd0));
        dir_rows.push_back(cfg_row(REG_BITS_RED, 4'd0));
        dir_rows.push_back(typed_row(32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0));
        // counts above eight, then fill the buffer and drop a byte
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd15));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd9));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hFF, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hFF, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hFF, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'h55, 32'h0));
        dir_rows.push_back(item_row(KIND_BYTE, 8'hAA, 32'h0));
        dir_rows.push_back(typed_row(32'h8000_0000, 32'h8000_FFFF, 1'b0, 1'b1));
        dir_rows.push_back(item_row(KIND_BYTE, 8'h7E, 32'h0));
        // extract: three bytes from one pixel, ignored byte, slow accumulation
        dir_rows.push_back(cfg_row(REG_EMBED_MODE, 4'd0));
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd8));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd8));
        dir_rows.push_back(cfg_row(REG_BITS_RED, 4'd8));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'h00A1_B2C3));
        dir_rows.push_back(item_row(KIND_BYTE, 8'h5A, 32'h0));
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd1));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd1));
        dir_rows.push_back(cfg_row(REG_BITS_RED, 4'd1));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'h0001_0101));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'h0000_0100));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'h00FF_FFFF));
        dir_rows.push_back(cfg_row(REG_BITS_BLUE, 4'd0));
        dir_rows.push_back(cfg_row(REG_BITS_GREEN, 4'd0));
        dir_rows.push_back(cfg_row(REG_BITS_RED, 4'd0));
        dir_rows.push_back(item_row(KIND_PIXEL, 8'h00, 32'hFFFF_FFFF));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.op == ROW_CFG) begin
                if (!cfg_valid)
                    drain_block();
                cfg_write(row.idx, row.val);
            end else begin
                if (cfg_valid)
                    cfg_valid <= 1'b0;
                drive_item(row);
            end
        end

        // random phases, alternating embed and extract
        for (int ph = 0; ph < 6; ph++) begin
            drain_block();
            mode_val    = 4'($urandom);
            mode_val[0] = (ph % 2 == 0);
            cfg_write(REG_EMBED_MODE, mode_val);
            cfg_write(REG_BITS_BLUE, pick_bits());
            cfg_write(REG_BITS_GREEN, pick_bits());
            cfg_write(REG_BITS_RED, pick_bits());
            cfg_valid <= 1'b0;
            calm_input = ($urandom_range(0, 3) == 0);
            counted    = 0;
            while (counted < 22) begin
                if (shadow_cfg.embed_mode) begin
                    // keep the buffer fed about as fast as pixels drain it
                    need = chan_bits(shadow_cfg.bits_blue) + chan_bits(shadow_cfg.bits_green)
                           + chan_bits(shadow_cfg.bits_red);
                    take_byte = (stash_cnt < need) ? ($urandom_range(0, 99) < 75)
                                                   : ($urandom_range(0, 99) < 30);
                    counted++;
                end else begin
                    take_byte = ($urandom_range(0, 99) < 15);
                    if (!take_byte)
                        counted++;
                end
                case ($urandom_range(0, 9))
                    0:       pix = 32'hFFFF_FFFF;
                    1:       pix = 32'h0000_0000;
                    default: pix = $urandom;
                endcase
                drive_item(item_row(take_byte ? KIND_BYTE : KIND_PIXEL, 8'($urandom), pix));
            end
        end

        // wind down
        s_axis_tvalid <= 1'b0;
        while (lsb_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
